/* rtl/pwsa_pkg.sv */
// Package for the perspective warp source address block.
// Holds the widths, the image size, register indexes and the shared structs.
// Depends on nothing; every module of the block imports it.
package pwsa_pkg;

    localparam int COEF_W     = 48;
    localparam int COORD_W    = 12;
    localparam int CTR_W      = COORD_W + 2;      // signed doubled pixel centre
    localparam int PROD_W     = COEF_W + CTR_W;   // one coefficient product
    localparam int ACC_W      = 64;               // sums scaled by 2^33
    localparam int IDX_W      = 24;
    localparam int QBITS      = 12;               // quotient bits worked out
    localparam int DSH_W      = ACC_W + QBITS;    // divisor shifted for the range check
    localparam int IMG_WIDTH  = 4096;
    localparam int IMG_HEIGHT = 4096;
    localparam int DIV_STAGES = QBITS + 1;        // preparation plus one stage a bit
    localparam int NUM_STAGES = 3 + DIV_STAGES + 1;

    // Twice the bottom-right coefficient (1.0 in Q16.32).
    localparam logic signed [ACC_W-1:0] TWO_ONE = ACC_W'(64'sd8589934592);
    localparam logic signed [COEF_W-1:0] ONE_Q32 = COEF_W'(48'sd4294967296);

    typedef enum logic [2:0] {
        REG_A00 = 3'd0,
        REG_A01 = 3'd1,
        REG_A02 = 3'd2,
        REG_A10 = 3'd3,
        REG_A11 = 3'd4,
        REG_A12 = 3'd5,
        REG_A20 = 3'd6,
        REG_A21 = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] a00;
        logic signed [COEF_W-1:0] a01;
        logic signed [COEF_W-1:0] a02;
        logic signed [COEF_W-1:0] a10;
        logic signed [COEF_W-1:0] a11;
        logic signed [COEF_W-1:0] a12;
        logic signed [COEF_W-1:0] a20;
        logic signed [COEF_W-1:0] a21;
    } coef_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] tu2;
        logic signed [ACC_W-1:0] tv2;
        logic signed [ACC_W-1:0] tw2;
    } proj_t;

    typedef struct packed {
        logic              degen;
        logic              neg_u;
        logic              neg_v;
        logic              ovf_u;
        logic              ovf_v;
        logic [QBITS-1:0]  q_u;
        logic [QBITS-1:0]  q_v;
    } div_res_t;

    // Magnitude of a signed value whose size stays below 2^63.
    function automatic logic [ACC_W-1:0] magnitude(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] r;
        begin
            r = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
            return r;
        end
    endfunction

endpackage

/* rtl/pwsa_mac.sv */
// Projective numerators and divisor: six products, then three sums.
// Two register stages. Depends on pwsa_pkg.
module pwsa_mac (
    input  logic                          clk,
    input  logic [1:0]                    en,
    input  pwsa_pkg::coef_t               coef,
    input  logic [pwsa_pkg::CTR_W-2:0]    xc2,
    input  logic [pwsa_pkg::CTR_W-2:0]    yc2,
    output pwsa_pkg::proj_t               proj
);
    import pwsa_pkg::*;

    logic signed [CTR_W-1:0]  xs;
    logic signed [CTR_W-1:0]  ys;
    logic signed [PROD_W-1:0] p_u0_reg, p_u1_reg, p_v0_reg, p_v1_reg, p_w0_reg, p_w1_reg;
    proj_t                    proj_reg;

    assign xs = $signed({1'b0, xc2});
    assign ys = $signed({1'b0, yc2});

    // Product stage: each coefficient times a doubled pixel centre.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_u0_reg <= PROD_W'(coef.a00) * PROD_W'(xs);
            p_u1_reg <= PROD_W'(coef.a01) * PROD_W'(ys);
            p_v0_reg <= PROD_W'(coef.a10) * PROD_W'(xs);
            p_v1_reg <= PROD_W'(coef.a11) * PROD_W'(ys);
            p_w0_reg <= PROD_W'(coef.a20) * PROD_W'(xs);
            p_w1_reg <= PROD_W'(coef.a21) * PROD_W'(ys);
        end
    end

    // Sum stage: rows of the matrix, all scaled by 2^33.
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            proj_reg.tu2 <= ACC_W'(p_u0_reg) + ACC_W'(p_u1_reg) + (ACC_W'(coef.a02) <<< 1);
            proj_reg.tv2 <= ACC_W'(p_v0_reg) + ACC_W'(p_v1_reg) + (ACC_W'(coef.a12) <<< 1);
            proj_reg.tw2 <= ACC_W'(p_w0_reg) + ACC_W'(p_w1_reg) + TWO_ONE;
        end
    end

    assign proj = proj_reg;

endmodule

/* rtl/pwsa_div.sv */
// Pipelined restoring divider for both source coordinates, one quotient
// bit a stage, after a preparation stage. Depends on pwsa_pkg.
module pwsa_div (
    input  logic                           clk,
    input  logic [pwsa_pkg::DIV_STAGES-1:0] en,
    input  pwsa_pkg::proj_t                proj,
    output pwsa_pkg::div_res_t             res
);
    import pwsa_pkg::*;

    logic signed [ACC_W-1:0] n_u;
    logic signed [ACC_W-1:0] n_v;
    logic signed [ACC_W-1:0] d_s;
    logic [ACC_W-1:0]        nm_u;
    logic [ACC_W-1:0]        nm_v;
    logic [ACC_W-1:0]        dm;

    logic [ACC_W-1:0] rem_u_reg [0:QBITS];
    logic [ACC_W-1:0] rem_v_reg [0:QBITS];
    logic [ACC_W-1:0] dm_reg    [0:QBITS];
    div_res_t         st_reg    [0:QBITS];

    // Shift the half pixel in: n = 2*num - den, d = 2*den.
    assign n_u  = (proj.tu2 <<< 1) - proj.tw2;
    assign n_v  = (proj.tv2 <<< 1) - proj.tw2;
    assign d_s  = proj.tw2 <<< 1;
    assign nm_u = magnitude(n_u);
    assign nm_v = magnitude(n_v);
    assign dm   = magnitude(d_s);

    // Preparation: signs, magnitudes and the range check on the quotient.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_u_reg[0]    <= nm_u;
            rem_v_reg[0]    <= nm_v;
            dm_reg[0]       <= dm;
            st_reg[0].degen <= (proj.tw2 == '0);
            st_reg[0].neg_u <= n_u[ACC_W-1] ^ d_s[ACC_W-1];
            st_reg[0].neg_v <= n_v[ACC_W-1] ^ d_s[ACC_W-1];
            st_reg[0].ovf_u <= {{QBITS{1'b0}}, nm_u} >= {dm, {QBITS{1'b0}}};
            st_reg[0].ovf_v <= {{QBITS{1'b0}}, nm_v} >= {dm, {QBITS{1'b0}}};
            st_reg[0].q_u   <= '0;
            st_reg[0].q_v   <= '0;
        end
    end

    // One compare and subtract per coordinate in each bit stage.
    for (genvar j = 0; j < QBITS; j++)
    begin : g_bit
        localparam int B = QBITS - 1 - j;
        logic [DSH_W-1:0] dsh;
        logic             take_u;
        logic             take_v;
        div_res_t         st_next;

        assign dsh    = {{QBITS{1'b0}}, dm_reg[j]} << B;
        assign take_u = {{QBITS{1'b0}}, rem_u_reg[j]} >= dsh;
        assign take_v = {{QBITS{1'b0}}, rem_v_reg[j]} >= dsh;

        // Status of the beat with this stage's quotient bits filled in.
        always_comb
        begin
            st_next        = st_reg[j];
            st_next.q_u[B] = take_u;
            st_next.q_v[B] = take_v;
        end

        always_ff @(posedge clk)
        begin
            if (en[j+1])
            begin
                rem_u_reg[j+1] <= take_u ? rem_u_reg[j] - dsh[ACC_W-1:0] : rem_u_reg[j];
                rem_v_reg[j+1] <= take_v ? rem_v_reg[j] - dsh[ACC_W-1:0] : rem_v_reg[j];
                dm_reg[j+1]    <= dm_reg[j];
                st_reg[j+1]    <= st_next;
            end
        end
    end

    assign res = st_reg[QBITS];

endmodule

/* rtl/perspective_warp_source_address_top.sv */
// Top level of the perspective warp source address block: coefficient
// registers, stage handshake, output stage. Uses pwsa_pkg, pwsa_mac, pwsa_div.
//
//  Channel   Direction  Beat contents
//  s_*       in         tdata: dst_x, dst_y
//  m_*       out        tdata: src_x, src_y, src_index; tuser: inside_res, degenerate
//  cfg_*     in         one coefficient write per cycle, no read-back
//
// There are 17 register stages: input, product, sum, divider preparation,
// 12 quotient-bit stages and output. A beat passes through them in that order,
// and one beat is accepted every cycle when nothing stalls.
// Each stage holds its beat only while the next one is full and stalled, so bubbles close up.
// Reset clears the valid bits and loads the identity matrix.
module perspective_warp_source_address_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,   // dst_x[11:0], dst_y[23:12]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [47:0]                  m_tdata,   // src_x[11:0], src_y[23:12], src_index[47:24]
    output logic [1:0]                   m_tuser,   // inside_res[0], degenerate[1]
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_addr,
    input  logic [pwsa_pkg::COEF_W-1:0]  cfg_wdata
);
    import pwsa_pkg::*;

    coef_t                 coef_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES:0]   en;
    logic [CTR_W-2:0]      xc2_reg;
    logic [CTR_W-2:0]      yc2_reg;
    proj_t                 proj;
    div_res_t              dres;
    logic                  in_image;
    logic [COORD_W-1:0]    sx_reg, sy_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  inside_reg, degen_reg;

    // Coefficient registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.a00 <= ONE_Q32;
            coef_reg.a01 <= '0;
            coef_reg.a02 <= '0;
            coef_reg.a10 <= '0;
            coef_reg.a11 <= ONE_Q32;
            coef_reg.a12 <= '0;
            coef_reg.a20 <= '0;
            coef_reg.a21 <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_A00: coef_reg.a00 <= cfg_wdata;
                REG_A01: coef_reg.a01 <= cfg_wdata;
                REG_A02: coef_reg.a02 <= cfg_wdata;
                REG_A10: coef_reg.a10 <= cfg_wdata;
                REG_A11: coef_reg.a11 <= cfg_wdata;
                REG_A12: coef_reg.a12 <= cfg_wdata;
                REG_A20: coef_reg.a20 <= cfg_wdata;
                REG_A21: coef_reg.a21 <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or its own beat moves on.
    always_comb
    begin
        en[NUM_STAGES] = m_tready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Input stage: doubled pixel centres 2*x + 1.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xc2_reg <= {s_tdata[COORD_W-1:0], 1'b1};
            yc2_reg <= {s_tdata[2*COORD_W-1:COORD_W], 1'b1};
        end
    end

    pwsa_mac u_mac (
        .clk  (clk),
        .en   (en[2:1]),
        .coef (coef_reg),
        .xc2  (xc2_reg),
        .yc2  (yc2_reg),
        .proj (proj)
    );

    pwsa_div u_div (
        .clk  (clk),
        .en   (en[DIV_STAGES+2:3]),
        .proj (proj),
        .res  (dres)
    );

    // A negative quotient is inside only when it truncates to zero.
    assign in_image = !dres.degen && !dres.ovf_u && !dres.ovf_v
                   && (!dres.neg_u || dres.q_u == '0)
                   && (!dres.neg_v || dres.q_v == '0)
                   && ({1'b0, dres.q_u} < (COORD_W+1)'(IMG_WIDTH))
                   && ({1'b0, dres.q_v} < (COORD_W+1)'(IMG_HEIGHT));

    // Output stage.
    always_ff @(posedge clk)
    begin
        if (en[NUM_STAGES-1])
        begin
            inside_reg <= in_image;
            degen_reg  <= dres.degen;
            sx_reg     <= in_image ? dres.q_u : '0;
            sy_reg     <= in_image ? dres.q_v : '0;
            idx_reg    <= in_image ? IDX_W'(32'(dres.q_v) * IMG_WIDTH + 32'(dres.q_u)) : '0;
        end
    end

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = {idx_reg, sy_reg, sx_reg};
    assign m_tuser  = {degen_reg, inside_reg};

    a_degen_outside: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("degenerate beat marked inside");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("outside beat carries a non-zero address");

    a_index_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[47:24] == {m_tdata[23:12], m_tdata[11:0]})
        else $error("linear index disagrees with coordinates");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[NUM_STAGES-1] |-> s_tready)
        else $error("input stalled with an empty output stage");

endmodule
